// ===== hdl/fesg_pkg.sv =====
// Shared field widths, codes and the result record for the file extent segment generator.
package fesg_pkg;

  localparam int KIND_W     = 2;
  localparam int INO_FLD_W  = 6;
  localparam int SLOT_W     = 10;
  localparam int VAL_W      = 23;
  localparam int LEN_W      = 18;
  localparam int STAT_W     = 3;
  localparam int BN_W       = 16;
  localparam int SB_W       = 12;
  localparam int BC_W       = 13;
  localparam int TOT_W      = 18;
  localparam int ICNT_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEN_W-1:0] LEN_LIMIT   = 18'd258048;
  localparam logic [BN_W-1:0]  BN_MAX      = 16'hFFFF;
  localparam int               MAX_RESULTS = 64;
  localparam int               RES_CNT_W   = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_LEN = 2'd0,
    KIND_LOAD_BLK = 2'd1,
    KIND_READ     = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_SEGMENT   = 3'd0,
    ST_BAD_INODE = 3'd1,
    ST_NOTHING   = 3'd2,
    ST_BAD_BLOCK = 3'd3,
    ST_LOAD_ACK  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INODE_COUNT      = 1'b0,
    CFG_DATA_BLOCK_COUNT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    status_t           status;
    logic [BN_W-1:0]   block_number;
    logic [SB_W-1:0]   start_byte;
    logic [BC_W-1:0]   byte_count;
    logic [TOT_W-1:0]  bytes_so_far;
    logic              last;
  } out_item_t;

endpackage

// ===== hdl/fesg_len_mem.sv =====
// Per-inode file length memory with per-entry valid bits; unwritten entries read as zero.
module fesg_len_mem #(
  parameter int INODES = 64,
  localparam int INO_W = (INODES > 1) ? $clog2(INODES) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [INO_W-1:0]             rd_addr,
  input  logic                         we,
  input  logic [INO_W-1:0]             wr_addr,
  input  logic [fesg_pkg::VAL_W-1:0]   wdata,
  output logic [fesg_pkg::VAL_W-1:0]   rd_data
);
  import fesg_pkg::*;

  logic [VAL_W-1:0] mem_r [INODES];
  logic [INODES-1:0] vld_r;
  logic [VAL_W-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== hdl/fesg_blk_mem.sv =====
// Block number table: one write port, one registered read port.
module fesg_blk_mem #(
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  input  logic                        we,
  input  logic [AW-1:0]               wr_addr,
  input  logic [fesg_pkg::BN_W-1:0]   wdata,
  output logic [fesg_pkg::BN_W-1:0]   rd_data
);
  import fesg_pkg::*;

  logic [BN_W-1:0] mem_r [DEPTH];
  logic [BN_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/fesg_ctrl.sv =====
// Sequencer: item decode, request clipping, per-block segment loop and result register.
module fesg_ctrl #(
  parameter int BLOCK_BYTES      = 4096,
  parameter int INODES           = 64,
  parameter int BLOCKS_PER_INODE = 1024,
  localparam int INO_W    = (INODES > 1) ? $clog2(INODES) : 1,
  localparam int BT_DEPTH = INODES * BLOCKS_PER_INODE,
  localparam int AW       = (BT_DEPTH > 1) ? $clog2(BT_DEPTH) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fesg_pkg::KIND_W-1:0]      in_kind,
  input  logic [fesg_pkg::INO_FLD_W-1:0]   in_inode_index,
  input  logic [fesg_pkg::SLOT_W-1:0]      in_block_slot,
  input  logic [fesg_pkg::VAL_W-1:0]       in_load_value,
  input  logic [fesg_pkg::VAL_W-1:0]       in_byte_offset,
  input  logic [fesg_pkg::LEN_W-1:0]       in_byte_length,
  input  logic                             cfg_write_en,
  input  logic [fesg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fesg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                             len_rd_en,
  output logic [INO_W-1:0]                 len_rd_addr,
  output logic                             len_we,
  output logic [INO_W-1:0]                 len_wr_addr,
  output logic [fesg_pkg::VAL_W-1:0]       len_wdata,
  input  logic [fesg_pkg::VAL_W-1:0]       len_rd_data,
  output logic                             blk_rd_en,
  output logic [AW-1:0]                    blk_rd_addr,
  output logic                             blk_we,
  output logic [AW-1:0]                    blk_wr_addr,
  output logic [fesg_pkg::BN_W-1:0]        blk_wdata,
  input  logic [fesg_pkg::BN_W-1:0]        blk_rd_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fesg_pkg::out_item_t              out_item
);
  import fesg_pkg::*;

  localparam int BB_W     = $clog2(BLOCK_BYTES);
  localparam int BI_W     = VAL_W - BB_W;
  localparam int FILE_MAX = BLOCKS_PER_INODE * BLOCK_BYTES;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DISP = 5'b00010,
    S_CHK  = 5'b00100,
    S_RD   = 5'b01000,
    S_SEG  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [KIND_W-1:0]     kind_r;
  logic [INO_FLD_W-1:0]  ino_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [VAL_W-1:0]      val_r;
  logic [VAL_W-1:0]      off_r;
  logic [LEN_W-1:0]      len_r;
  logic [AW-1:0]         base_r;
  logic [VAL_W-1:0]      end_r, end_nxt;
  logic                  bad_r, bad_nxt;
  logic                  none_r, none_nxt;
  logic [BI_W-1:0]       blk_i_r, blk_i_nxt;
  logic [BI_W-1:0]       last_i_r, last_i_nxt;
  logic [BB_W:0]         stop_last_r, stop_last_nxt;
  logic                  first_r, first_nxt;
  logic [TOT_W-1:0]      total_r, total_nxt;
  logic [RES_CNT_W-1:0]  n_r, n_nxt;
  logic [ICNT_W-1:0]     icnt_r;
  logic [BN_W-1:0]       dbc_r;
  logic                  out_valid_r;
  out_item_t             out_item_r;

  logic                  accept;
  logic                  out_free;
  logic                  push;
  out_item_t             item_nxt;
  logic [VAL_W:0]        sum;
  logic [VAL_W-1:0]      end_m1;
  logic [BB_W-1:0]       sb;
  logic [BB_W:0]         stop;
  logic [BB_W:0]         cnt;
  logic [TOT_W-1:0]      tot;
  logic                  is_last;
  logic                  fin;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign len_rd_en   = accept;
  assign len_rd_addr = INO_W'(in_inode_index);
  assign len_wr_addr = INO_W'(ino_r);
  assign len_wdata   = (int'(val_r) > FILE_MAX) ? VAL_W'(FILE_MAX) : val_r;
  assign blk_wr_addr = base_r + AW'(slot_r);
  assign blk_wdata   = (val_r > VAL_W'(BN_MAX)) ? BN_MAX : val_r[BN_W-1:0];
  assign blk_rd_addr = base_r + AW'(blk_i_r);

  assign sum     = {1'b0, off_r} + (VAL_W + 1)'(len_r);
  assign end_m1  = end_r - VAL_W'(1);
  assign sb      = first_r ? off_r[BB_W-1:0] : '0;
  assign is_last = (blk_i_r == last_i_r);
  assign stop    = is_last ? stop_last_r : (BB_W + 1)'(BLOCK_BYTES);
  assign cnt     = stop - {1'b0, sb};
  assign tot     = total_r + TOT_W'(cnt);
  assign fin     = is_last || (n_r == RES_CNT_W'(MAX_RESULTS - 1));

  always_comb begin
    state_nxt     = state_r;
    push          = 1'b0;
    item_nxt      = '0;
    len_we        = 1'b0;
    blk_we        = 1'b0;
    blk_rd_en     = 1'b0;
    end_nxt       = end_r;
    bad_nxt       = bad_r;
    none_nxt      = none_r;
    blk_i_nxt     = blk_i_r;
    last_i_nxt    = last_i_r;
    stop_last_nxt = stop_last_r;
    first_nxt     = first_r;
    total_nxt     = total_r;
    n_nxt         = n_r;
    item_nxt.last = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (kind_t'(kind_r))
          KIND_LOAD_LEN: begin
            item_nxt.status = ST_LOAD_ACK;
            if (out_free) begin
              push      = 1'b1;
              len_we    = (int'(ino_r) < INODES);
              state_nxt = S_IDLE;
            end
          end
          KIND_LOAD_BLK: begin
            item_nxt.status = ST_LOAD_ACK;
            if (out_free) begin
              push      = 1'b1;
              blk_we    = (int'(ino_r) < INODES) && (int'(slot_r) < BLOCKS_PER_INODE);
              state_nxt = S_IDLE;
            end
          end
          KIND_READ: begin
            bad_nxt   = ({1'b0, ino_r} >= icnt_r) || (int'(ino_r) >= INODES);
            none_nxt  = (off_r >= len_rd_data) || (len_r == '0);
            end_nxt   = (sum > {1'b0, len_rd_data}) ? len_rd_data : sum[VAL_W-1:0];
            state_nxt = S_CHK;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_CHK: begin
        if (bad_r || none_r) begin
          item_nxt.status = bad_r ? ST_BAD_INODE : ST_NOTHING;
          if (out_free) begin
            push      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          blk_i_nxt     = off_r[VAL_W-1:BB_W];
          last_i_nxt    = end_m1[VAL_W-1:BB_W];
          stop_last_nxt = {1'b0, end_m1[BB_W-1:0]} + (BB_W + 1)'(1);
          first_nxt     = 1'b1;
          total_nxt     = '0;
          n_nxt         = '0;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        if (int'(blk_i_r) >= BLOCKS_PER_INODE) begin
          item_nxt.status       = ST_BAD_BLOCK;
          item_nxt.bytes_so_far = total_r;
          if (out_free) begin
            push      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          blk_rd_en = 1'b1;
          state_nxt = S_SEG;
        end
      end
      S_SEG: begin
        item_nxt.block_number = blk_rd_data;
        if (blk_rd_data >= dbc_r) begin
          item_nxt.status       = ST_BAD_BLOCK;
          item_nxt.bytes_so_far = total_r;
          if (out_free) begin
            push      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          item_nxt.status       = ST_SEGMENT;
          item_nxt.start_byte   = SB_W'(sb);
          item_nxt.byte_count   = BC_W'(cnt);
          item_nxt.bytes_so_far = tot;
          item_nxt.last         = fin;
          if (out_free) begin
            push      = 1'b1;
            total_nxt = tot;
            if (fin) begin
              state_nxt = S_IDLE;
            end else begin
              blk_i_nxt = blk_i_r + BI_W'(1);
              n_nxt     = n_r + RES_CNT_W'(1);
              first_nxt = 1'b0;
              state_nxt = S_RD;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      icnt_r      <= '0;
      dbc_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_write_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_INODE_COUNT:      icnt_r <= cfg_wdata[ICNT_W-1:0];
          CFG_DATA_BLOCK_COUNT: dbc_r  <= cfg_wdata[BN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      ino_r  <= in_inode_index;
      slot_r <= in_block_slot;
      val_r  <= in_load_value;
      off_r  <= in_byte_offset;
      len_r  <= (in_byte_length > LEN_LIMIT) ? LEN_LIMIT : in_byte_length;
      base_r <= AW'(in_inode_index) * AW'(BLOCKS_PER_INODE);
    end
    if (push) begin
      out_item_r <= item_nxt;
    end
    end_r       <= end_nxt;
    bad_r       <= bad_nxt;
    none_r      <= none_nxt;
    blk_i_r     <= blk_i_nxt;
    last_i_r    <= last_i_nxt;
    stop_last_r <= stop_last_nxt;
    first_r     <= first_nxt;
    total_r     <= total_nxt;
    n_r         <= n_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hdl/file_extent_segment_generator.sv =====
// File extent segment generator: top level.
//
// Input channel (in_*): one item per transfer. Kind 0 loads an inode's file
// length, kind 1 loads one block table entry, kind 2 is a read request, kind 3
// is dropped without a result. Output channel (out_*): one result per transfer.
// Loads give one acknowledge; a read gives one status result, or one segment per
// block touched (max 64), maybe ended by a bad block status; last has out_last.
// Config port (cfg_*): inode count at index 0, data block count at index 1;
// write only while no item is in flight.
// Sequencing: an item is taken only when the sequencer is idle. A load or a
// dropped item is handled in S_DISP. A read that fails the inode or length
// check gets its status result from S_CHK, after the checks in S_DISP. Any
// other read passes S_DISP and S_CHK, then runs S_RD and S_SEG once per
// result: S_RD issues a registered block table read, and S_SEG forms the
// result from its data.
// A single output register holds results; a result that finds it full while
// out_ready is low waits in place, and no new item is taken. Reset clears the
// counts, the file length valid bits (lengths read as zero) and all handshake
// state; the block table is not cleared and must be loaded before use.
module file_extent_segment_generator #(
  parameter int BLOCK_BYTES      = 4096,
  parameter int INODES           = 64,
  parameter int BLOCKS_PER_INODE = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fesg_pkg::KIND_W-1:0]      in_kind,
  input  logic [fesg_pkg::INO_FLD_W-1:0]   in_inode_index,
  input  logic [fesg_pkg::SLOT_W-1:0]      in_block_slot,
  input  logic [fesg_pkg::VAL_W-1:0]       in_load_value,
  input  logic [fesg_pkg::VAL_W-1:0]       in_byte_offset,
  input  logic [fesg_pkg::LEN_W-1:0]       in_byte_length,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fesg_pkg::STAT_W-1:0]      out_status,
  output logic [fesg_pkg::BN_W-1:0]        out_block_number,
  output logic [fesg_pkg::SB_W-1:0]        out_start_byte,
  output logic [fesg_pkg::BC_W-1:0]        out_byte_count,
  output logic [fesg_pkg::TOT_W-1:0]       out_bytes_so_far,
  output logic                             out_last,
  input  logic                             cfg_write_en,
  input  logic [fesg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fesg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fesg_pkg::*;

  localparam int INO_W    = (INODES > 1) ? $clog2(INODES) : 1;
  localparam int BT_DEPTH = INODES * BLOCKS_PER_INODE;
  localparam int AW       = (BT_DEPTH > 1) ? $clog2(BT_DEPTH) : 1;

  logic              len_rd_en;
  logic [INO_W-1:0]  len_rd_addr;
  logic              len_we;
  logic [INO_W-1:0]  len_wr_addr;
  logic [VAL_W-1:0]  len_wdata;
  logic [VAL_W-1:0]  len_rd_data;
  logic              blk_rd_en;
  logic [AW-1:0]     blk_rd_addr;
  logic              blk_we;
  logic [AW-1:0]     blk_wr_addr;
  logic [BN_W-1:0]   blk_wdata;
  logic [BN_W-1:0]   blk_rd_data;
  out_item_t         out_item;

  fesg_len_mem #(
    .INODES (INODES)
  ) u_len_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (len_rd_en),
    .rd_addr (len_rd_addr),
    .we      (len_we),
    .wr_addr (len_wr_addr),
    .wdata   (len_wdata),
    .rd_data (len_rd_data)
  );

  fesg_blk_mem #(
    .DEPTH (BT_DEPTH)
  ) u_blk_mem (
    .clk     (clk),
    .rd_en   (blk_rd_en),
    .rd_addr (blk_rd_addr),
    .we      (blk_we),
    .wr_addr (blk_wr_addr),
    .wdata   (blk_wdata),
    .rd_data (blk_rd_data)
  );

  fesg_ctrl #(
    .BLOCK_BYTES      (BLOCK_BYTES),
    .INODES           (INODES),
    .BLOCKS_PER_INODE (BLOCKS_PER_INODE)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_inode_index (in_inode_index),
    .in_block_slot  (in_block_slot),
    .in_load_value  (in_load_value),
    .in_byte_offset (in_byte_offset),
    .in_byte_length (in_byte_length),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .len_rd_en      (len_rd_en),
    .len_rd_addr    (len_rd_addr),
    .len_we         (len_we),
    .len_wr_addr    (len_wr_addr),
    .len_wdata      (len_wdata),
    .len_rd_data    (len_rd_data),
    .blk_rd_en      (blk_rd_en),
    .blk_rd_addr    (blk_rd_addr),
    .blk_we         (blk_we),
    .blk_wr_addr    (blk_wr_addr),
    .blk_wdata      (blk_wdata),
    .blk_rd_data    (blk_rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item)
  );

  assign out_status       = out_item.status;
  assign out_block_number = out_item.block_number;
  assign out_start_byte   = out_item.start_byte;
  assign out_byte_count   = out_item.byte_count;
  assign out_bytes_so_far = out_item.bytes_so_far;
  assign out_last         = out_item.last;

  a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input transfer taken while an item is in flight");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BAD_INODE || out_status == ST_NOTHING ||
                  out_status == ST_BAD_BLOCK || out_status == ST_LOAD_ACK) |-> out_last)
    else $error("status result without last mark");

  a_segment_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SEGMENT |-> out_byte_count != '0)
    else $error("empty segment");

  a_blk_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(blk_we && blk_rd_en))
    else $error("block table read and write in the same cycle");

endmodule
